// ----- rtl/arpr_pkg.sv -----
`default_nettype none
package arpr_pkg;

  // frame limits
  localparam int MAX_FRAME_BYTES = 256;
  localparam int HDR_LEN         = 42;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int ADDR_W          = $clog2(HDR_LEN);
  localparam int MAC_W           = 48;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(HDR_LEN - 1);

  // header positions of interest
  localparam int IDX_TYPE_HI = 12;
  localparam int IDX_TYPE_LO = 13;
  localparam int IDX_OPCODE  = 21;

  localparam logic [7:0] ETYPE_ARP_HI = 8'h08;
  localparam logic [7:0] ETYPE_ARP_LO = 8'h06;
  localparam logic [7:0] OP_REQUEST   = 8'h01;
  localparam logic [7:0] OP_REPLY     = 8'h02;

  // reply bytes 12..21: EtherType, htype, ptype, hlen, plen, opcode
  localparam logic [7:0] ARP_FIXED [10] = '{
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
  };

  typedef enum logic {ACT_BYTE = 1'b0, ACT_ARM = 1'b1} act_t;
  typedef enum logic {KIND_BYTE = 1'b0, KIND_NOTICE = 1'b1} kind_t;
  typedef enum logic {JOB_REPLY = 1'b0, JOB_NOTICE = 1'b1} job_t;
  typedef enum logic {TX_IDLE, TX_SEND} tx_state_t;
  typedef enum logic [1:0] {SRC_RAM, SRC_MAC, SRC_FIX} src_kind_t;

  typedef struct packed {
    src_kind_t         src;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        mac_idx;
    logic [7:0]        fix;
  } src_sel_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } out_item_t;

  // where reply byte idx comes from
  function automatic src_sel_t reply_src(logic [ADDR_W-1:0] idx);
    src_sel_t s;
    s.src     = SRC_FIX;
    s.addr    = '0;
    s.mac_idx = '0;
    s.fix     = '0;
    case (idx) inside
      [0:5]: begin
        s.src  = SRC_RAM;
        s.addr = idx + ADDR_W'(6);
      end
      [6:11]: begin
        s.src     = SRC_MAC;
        s.mac_idx = 3'(idx - ADDR_W'(6));
      end
      [12:21]: begin
        s.fix = ARP_FIXED[4'(idx - ADDR_W'(12))];
      end
      [22:27]: begin
        s.src     = SRC_MAC;
        s.mac_idx = 3'(idx - ADDR_W'(22));
      end
      [28:31]: begin
        s.src  = SRC_RAM;
        s.addr = idx + ADDR_W'(10);
      end
      [32:41]: begin
        s.src  = SRC_RAM;
        s.addr = idx - ADDR_W'(10);
      end
      default: begin
        s.fix = '0;
      end
    endcase
    return s;
  endfunction

  // byte k of the MAC, first byte most significant
  function automatic logic [7:0] mac_byte(logic [MAC_W-1:0] mac, logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      3'd5:    b = mac[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/arp_request_responder_top.sv -----
// Channel   Dir  Handshake              Payload
// in_       in   in_tvalid/in_tready    tdata=data_byte, tuser=action, tlast=frame_end
// out_      out  out_tvalid/out_tready  tdata=tx_byte, tuser=kind, tlast=tx_last
// cfg_      in   cfg_valid/cfg_ready    cfg_data=own_mac (48 bit)
//
// Received bytes are taken one per cycle while in_tready is high. A frame that
// ends as an ARP request makes in_tready drop until the reply's 42 header reads
// have left the header RAM; a notice does not block the input.
// The reply streams one byte per cycle while out_tready is high, set by the single
// read port of the header RAM; each byte passes the read stage and the output buffer.
// rst_n is synchronous, active low; cfg_ready is always high.
// Output stalls fill a 2-deep buffer, then reads stop; the job queue holds 2.
`default_nettype none
module arp_request_responder_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request stream in
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  wire logic                        in_tuser,   // [0] action
  input  wire logic                        in_tlast,   // frame_end
  // reply stream out
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] tx_byte
  output logic                             out_tuser,  // [0] kind
  output logic                             out_tlast,  // tx_last
  // own MAC write
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [arpr_pkg::MAC_W-1:0]  cfg_data
);

  logic                        ram_we;
  logic [arpr_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]                  ram_wdata, ram_rdata;
  logic                        job_push, job_pop, job_valid, job_full, reply_done;
  arpr_pkg::job_t              job_push_kind, job_head;

  // front: stores header bytes, classifies at frame end
  arpr_rx u_rx (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .job_push      (job_push),
    .job_push_kind (job_push_kind),
    .job_full      (job_full),
    .reply_done    (reply_done)
  );

  // header store, first 42 bytes of the frame
  arpr_ram #(
    .WIDTH (8),
    .DEPTH (arpr_pkg::HDR_LEN)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // jobs between front and back
  arpr_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_push_kind),
    .pop      (job_pop),
    .valid    (job_valid),
    .full     (job_full),
    .head     (job_head)
  );

  // back: builds reply or notice
  arpr_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .job_valid  (job_valid),
    .job        (job_head),
    .job_pop    (job_pop),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .reply_done (reply_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/arpr_ram.sv -----
`default_nettype none
module arpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 42
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/arpr_rx.sv -----
`default_nettype none
module arpr_rx (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,
  input  wire logic                        in_tuser,
  input  wire logic                        in_tlast,
  output logic                             ram_we,
  output logic [arpr_pkg::ADDR_W-1:0]      ram_waddr,
  output logic [7:0]                       ram_wdata,
  output logic                             job_push,
  output arpr_pkg::job_t                   job_push_kind,
  input  wire logic                        job_full,
  input  wire logic                        reply_done
);

  logic [arpr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                       armed_r, armed_nxt;
  logic                       pend_r, pend_nxt;
  logic [7:0]                 type_hi_r, type_lo_r, opcode_r;
  logic                       take_byte, is_arp, len_ok;

  assign in_tready = !pend_r && !job_full;
  assign take_byte = in_tvalid && in_tready && (in_tuser == arpr_pkg::ACT_BYTE);

  assign ram_we    = take_byte && (count_r < arpr_pkg::CNT_W'(arpr_pkg::HDR_LEN));
  assign ram_waddr = count_r[arpr_pkg::ADDR_W-1:0];
  assign ram_wdata = in_tdata;

  assign is_arp = (type_hi_r == arpr_pkg::ETYPE_ARP_HI) && (type_lo_r == arpr_pkg::ETYPE_ARP_LO);
  // length after this byte reaches the header size
  assign len_ok = count_r >= arpr_pkg::CNT_W'(arpr_pkg::HDR_LEN - 1);

  always_comb begin
    count_nxt     = count_r;
    armed_nxt     = armed_r;
    pend_nxt      = pend_r;
    job_push      = 1'b0;
    job_push_kind = arpr_pkg::JOB_REPLY;
    if (reply_done) begin
      pend_nxt = 1'b0;
    end
    if (in_tvalid && in_tready && (in_tuser == arpr_pkg::ACT_ARM)) begin
      armed_nxt = 1'b1;
    end
    if (take_byte) begin
      if (in_tlast) begin
        count_nxt = '0;
        if (armed_r && len_ok && is_arp) begin
          if (opcode_r == arpr_pkg::OP_REPLY) begin
            job_push      = 1'b1;
            job_push_kind = arpr_pkg::JOB_NOTICE;
            armed_nxt     = 1'b0;
          end else if (opcode_r == arpr_pkg::OP_REQUEST) begin
            job_push = 1'b1;
            pend_nxt = 1'b1;
          end
        end
      end else if (count_r < arpr_pkg::CNT_W'(arpr_pkg::MAX_FRAME_BYTES)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      armed_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      armed_r <= armed_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // classification bytes kept beside the RAM
  always_ff @(posedge clk) begin
    if (take_byte) begin
      if (count_r == arpr_pkg::CNT_W'(arpr_pkg::IDX_TYPE_HI)) begin
        type_hi_r <= in_tdata;
      end
      if (count_r == arpr_pkg::CNT_W'(arpr_pkg::IDX_TYPE_LO)) begin
        type_lo_r <= in_tdata;
      end
      if (count_r == arpr_pkg::CNT_W'(arpr_pkg::IDX_OPCODE)) begin
        opcode_r <= in_tdata;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/arpr_jobq.sv -----
`default_nettype none
module arpr_jobq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire arpr_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                valid,
  output logic                full,
  output arpr_pkg::job_t      head
);

  arpr_pkg::job_t slot_r [2];
  logic           wptr_r, rptr_r;
  logic [1:0]     cnt_r, cnt_nxt;

  assign valid = cnt_r != 2'd0;
  assign full  = cnt_r == 2'd2;
  assign head  = slot_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/arpr_tx.sv -----
`default_nettype none
module arpr_tx (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [arpr_pkg::MAC_W-1:0]  cfg_data,
  input  wire logic                        job_valid,
  input  wire arpr_pkg::job_t              job,
  output logic                             job_pop,
  output logic [arpr_pkg::ADDR_W-1:0]      ram_raddr,
  input  wire logic [7:0]                  ram_rdata,
  output logic                             reply_done,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [7:0]                       out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);

  logic [arpr_pkg::MAC_W-1:0]  own_mac_r;
  arpr_pkg::tx_state_t         state_r, state_nxt;
  logic [arpr_pkg::ADDR_W-1:0] idx_r, idx_nxt, issue_idx;
  arpr_pkg::src_sel_t          sel;
  logic [7:0]                  const_byte;

  // read stage: one request in flight towards the output buffer
  logic                        a_vld_r, a_vld_nxt;
  arpr_pkg::kind_t             a_kind_r, a_kind_nxt;
  logic                        a_last_r, a_last_nxt;
  logic                        a_ram_r, a_ram_nxt;
  logic [7:0]                  a_byte_r, a_byte_nxt;

  // two-entry output buffer
  arpr_pkg::out_item_t         slot0_r, slot1_r, landed;
  logic [1:0]                  occ_r;
  logic                        pop, can_issue;
  logic [2:0]                  occ_sum;

  assign cfg_ready = 1'b1;

  assign issue_idx  = (state_r == arpr_pkg::TX_IDLE) ? '0 : idx_r;
  assign sel        = arpr_pkg::reply_src(issue_idx);
  assign ram_raddr  = sel.addr;
  assign const_byte = (sel.src == arpr_pkg::SRC_MAC) ?
                      arpr_pkg::mac_byte(own_mac_r, sel.mac_idx) : sel.fix;

  assign pop       = out_tvalid && out_tready;
  assign occ_sum   = 3'(occ_r) + 3'(a_vld_r) - 3'(pop);
  assign can_issue = occ_sum <= 3'd1;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    job_pop    = 1'b0;
    reply_done = 1'b0;
    a_vld_nxt  = 1'b0;
    a_kind_nxt = arpr_pkg::KIND_BYTE;
    a_last_nxt = 1'b0;
    a_ram_nxt  = sel.src == arpr_pkg::SRC_RAM;
    a_byte_nxt = const_byte;
    case (state_r)
      arpr_pkg::TX_IDLE: begin
        if (job_valid && can_issue) begin
          job_pop   = 1'b1;
          a_vld_nxt = 1'b1;
          if (job == arpr_pkg::JOB_NOTICE) begin
            a_kind_nxt = arpr_pkg::KIND_NOTICE;
            a_last_nxt = 1'b1;
            a_ram_nxt  = 1'b0;
            a_byte_nxt = '0;
          end else begin
            idx_nxt   = arpr_pkg::ADDR_W'(1);
            state_nxt = arpr_pkg::TX_SEND;
          end
        end
      end
      arpr_pkg::TX_SEND: begin
        if (can_issue) begin
          a_vld_nxt = 1'b1;
          if (idx_r == arpr_pkg::LAST_IDX) begin
            a_last_nxt = 1'b1;
            reply_done = 1'b1;
            state_nxt  = arpr_pkg::TX_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = arpr_pkg::TX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      state_r   <= arpr_pkg::TX_IDLE;
      idx_r     <= '0;
      a_vld_r   <= 1'b0;
      occ_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        own_mac_r <= cfg_data;
      end
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      a_vld_r <= a_vld_nxt;
      case ({a_vld_r, pop})
        2'b10:   occ_r <= occ_r + 2'd1;
        2'b01:   occ_r <= occ_r - 2'd1;
        default: occ_r <= occ_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_kind_r <= a_kind_nxt;
    a_last_r <= a_last_nxt;
    a_ram_r  <= a_ram_nxt;
    a_byte_r <= a_byte_nxt;
  end

  assign landed.kind = a_kind_r;
  assign landed.data = a_ram_r ? ram_rdata : a_byte_r;
  assign landed.last = a_last_r;

  always_ff @(posedge clk) begin
    case ({a_vld_r, pop})
      2'b10: begin
        if (occ_r == 2'd0) begin
          slot0_r <= landed;
        end else begin
          slot1_r <= landed;
        end
      end
      2'b01: begin
        slot0_r <= slot1_r;
      end
      2'b11: begin
        if (occ_r == 2'd1) begin
          slot0_r <= landed;
        end else begin
          slot0_r <= slot1_r;
          slot1_r <= landed;
        end
      end
      default: begin
        slot0_r <= slot0_r;
      end
    endcase
  end

  assign out_tvalid = occ_r != 2'd0;
  assign out_tdata  = slot0_r.data;
  assign out_tuser  = slot0_r.kind;
  assign out_tlast  = slot0_r.last;

endmodule
`default_nettype wire

// ----- rtl/arpr_chk.sv -----
`default_nettype none
module arpr_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tuser,
  input wire logic       out_tlast
);

  // position of the next reply byte
  logic [arpr_pkg::ADDR_W-1:0] pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (out_tvalid && out_tready && (out_tuser == arpr_pkg::KIND_BYTE)) begin
      pos_r <= out_tlast ? '0 : pos_r + 1'b1;
    end
  end

  a_notice_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == arpr_pkg::KIND_NOTICE) |-> out_tlast && (out_tdata == 8'h00))
    else $error("notice not a single zero item");

  a_reply_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == arpr_pkg::KIND_BYTE) |->
      (out_tlast == (pos_r == arpr_pkg::LAST_IDX)))
    else $error("reply frame length wrong");

  a_reply_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == arpr_pkg::KIND_BYTE) &&
      (pos_r == arpr_pkg::ADDR_W'(arpr_pkg::IDX_TYPE_HI)) |-> out_tdata == arpr_pkg::ETYPE_ARP_HI)
    else $error("reply EtherType wrong");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

endmodule

bind arp_request_responder_top arpr_chk u_arpr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

// reply bytes 12..21: EtherType, htype, ptype, hlen, plen, opcode (reply)
localparam logic [7:0] REPLY_FIXED [10] = '{
  8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
};

typedef logic [7:0] frame_q_t [$];

// Tracks the received frame and queues the reply bytes or notice it should cause.
class arp_reply_tracker;
  logic [7:0]                 hdr [arpr_pkg::HDR_LEN];
  int unsigned                fill;
  bit                         armed;
  logic [arpr_pkg::MAC_W-1:0] own_mac;
  arpr_pkg::out_item_t        reply_bytes_due [$];
  int unsigned                errors;
  int unsigned                frames_ended;
  int unsigned                replies_built;
  int unsigned                notices_built;

  function new();
    foreach (hdr[i]) hdr[i] = '0;
    fill          = 0;
    armed         = 1'b0;
    own_mac       = '0;
    errors        = 0;
    frames_ended  = 0;
    replies_built = 0;
    notices_built = 0;
  endfunction

  function void set_own_mac(logic [arpr_pkg::MAC_W-1:0] mac);
    own_mac = mac;
  endfunction

  function void note_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function void note_request(arpr_pkg::act_t act, logic [7:0] b, logic last);
    logic [7:0]          frm [arpr_pkg::HDR_LEN];
    int unsigned         len;
    arpr_pkg::out_item_t it;
    if (act == arpr_pkg::ACT_ARM) begin
      armed = 1'b1;
      return;
    end
    if (fill < arpr_pkg::HDR_LEN) hdr[fill] = b;
    if (fill < arpr_pkg::MAX_FRAME_BYTES) fill++;
    if (!last) return;
    len  = fill;
    fill = 0;
    frames_ended++;
    if (!armed || len < arpr_pkg::HDR_LEN) return;
    if (hdr[arpr_pkg::IDX_TYPE_HI] != arpr_pkg::ETYPE_ARP_HI ||
        hdr[arpr_pkg::IDX_TYPE_LO] != arpr_pkg::ETYPE_ARP_LO) return;
    if (hdr[arpr_pkg::IDX_OPCODE] == arpr_pkg::OP_REPLY) begin
      armed   = 1'b0;
      it.kind = arpr_pkg::KIND_NOTICE;
      it.data = '0;
      it.last = 1'b1;
      reply_bytes_due.push_back(it);
      notices_built++;
      return;
    end
    if (hdr[arpr_pkg::IDX_OPCODE] != arpr_pkg::OP_REQUEST) return;
    for (int i = 0; i < 6; i++) begin
      frm[i]      = hdr[6 + i];
      frm[6 + i]  = own_mac[8 * (5 - i) +: 8];
      frm[22 + i] = own_mac[8 * (5 - i) +: 8];
      frm[32 + i] = hdr[22 + i];
    end
    for (int i = 0; i < 10; i++) frm[12 + i] = REPLY_FIXED[i];
    for (int i = 0; i < 4; i++) begin
      frm[28 + i] = hdr[38 + i];
      frm[38 + i] = hdr[28 + i];
    end
    for (int i = 0; i < arpr_pkg::HDR_LEN; i++) begin
      it.kind = arpr_pkg::KIND_BYTE;
      it.data = frm[i];
      it.last = (i == arpr_pkg::HDR_LEN - 1);
      reply_bytes_due.push_back(it);
    end
    replies_built++;
  endfunction

  function void check_reply(arpr_pkg::kind_t k, logic [7:0] d, logic last);
    arpr_pkg::out_item_t want;
    if (reply_bytes_due.size() == 0) begin
      note_error($sformatf("unexpected output kind=%0d byte=%02h last=%0d", k, d, last));
      return;
    end
    want = reply_bytes_due.pop_front();
    if (want.kind !== k || want.data !== d || want.last !== last)
      note_error($sformatf("kind %0d/%0d byte %02h/%02h last %0d/%0d (expected/actual)",
                           want.kind, k, want.data, d, want.last, last));
  endfunction
endclass

module testbench;

  // cycles with no handshake anywhere before the run is declared hung;
  // the worst honest gap is a long sender gap or a long output stall
  localparam int WATCHDOG_LIMIT = 3000;
  // pause before a MAC write: lets a frame that causes nothing finish inside the block
  localparam int SETTLE_CYCLES  = 12;
  localparam int END_CYCLES     = 20;

  // other byte values used to spoil the type or opcode fields
  localparam logic [7:0] OP_UNKNOWN    = 8'h03;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [7:0]                 in_tdata   = '0;
  logic                       in_tuser   = 1'b0;
  logic                       in_tlast   = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [7:0]                 out_tdata;
  logic                       out_tuser;
  logic                       out_tlast;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [arpr_pkg::MAC_W-1:0] cfg_data   = '0;

  arp_reply_tracker tracker;
  bit               steady_flow    = 1'b0;  // no gaps and no stalls while set
  int               requests_sent  = 0;
  int               mac_writes     = 0;
  int               quiet_cycles   = 0;
  int               ready_left     = 0;

  arp_request_responder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Frame of len bytes; fill < 0 gives random bytes. With op >= 0 the frame
  // carries the ARP EtherType and that opcode, as far as its length reaches.
  function automatic frame_q_t build_frame(int len, int op, int fill);
    frame_q_t f;
    for (int i = 0; i < len; i++) f.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    if (op >= 0) begin
      if (len > arpr_pkg::IDX_TYPE_HI) f[arpr_pkg::IDX_TYPE_HI] = arpr_pkg::ETYPE_ARP_HI;
      if (len > arpr_pkg::IDX_TYPE_LO) f[arpr_pkg::IDX_TYPE_LO] = arpr_pkg::ETYPE_ARP_LO;
      if (len > arpr_pkg::IDX_OPCODE)  f[arpr_pkg::IDX_OPCODE]  = 8'(op);
    end
    return f;
  endfunction

  // Offers one request after a random gap (none while steady_flow is set) and returns at the edge that takes it.
  // tvalid is left high; the next request or a hold-off decides its value.
  task automatic send_request(arpr_pkg::act_t act, logic [7:0] b, logic last);
    int gap;
    gap = steady_flow ? 0 : pick_pause();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  // arm_at >= 0 slips an arm request in ahead of that byte
  task automatic send_frame(frame_q_t frm, int arm_at);
    for (int i = 0; i < frm.size(); i++) begin
      if (i == arm_at) send_request(arpr_pkg::ACT_ARM, 8'($urandom), 1'($urandom));
      send_request(arpr_pkg::ACT_BYTE, frm[i], i == frm.size() - 1);
    end
  endtask

  // Sender holds off until every reply byte and notice due has come out.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.reply_bytes_due.size() != 0) @(posedge clk);
  endtask

  // Own MAC is only changed with the block idle.
  task automatic write_own_mac(logic [arpr_pkg::MAC_W-1:0] mac);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mac;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output back-pressure: runs of ready, broken by stalls of random length.
  always @(posedge clk) begin
    if (steady_flow) begin
      out_tready <= 1'b1;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      ready_left = pick_pause();
    end else begin
      out_tready <= 1'b1;
      ready_left = $urandom_range(0, 30);
    end
  end

  // Monitor: one process sees all three channels, so requests are noted
  // before any output of the same edge is checked. Also the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        tracker.note_request(arpr_pkg::act_t'(in_tuser), in_tdata, in_tlast);
      if (cfg_valid && cfg_ready) begin
        tracker.set_own_mac(cfg_data);
        mac_writes++;
      end
      if (out_tvalid && out_tready)
        tracker.check_reply(arpr_pkg::kind_t'(out_tuser), out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (cfg_valid && cfg_ready) ||
          (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d outputs still due",
                 quiet_cycles, tracker.reply_bytes_due.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    frame_q_t                   frm;
    logic [arpr_pkg::MAC_W-1:0] mac;

    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // own MAC all ones
    write_own_mac('1);
    // arm; its byte and tlast mean nothing
    send_request(arpr_pkg::ACT_ARM, 8'hFF, 1'b1);
    // one byte short of a header: nothing
    send_frame(build_frame(arpr_pkg::HDR_LEN - 1, arpr_pkg::OP_REQUEST, -1), -1);
    // exact-length request, other bytes ones, arm slipped in mid-frame: reply
    send_frame(build_frame(arpr_pkg::HDR_LEN, arpr_pkg::OP_REQUEST, 8'hFF), 17);
    // random own MAC, written once the reply has drained
    mac = arpr_pkg::MAC_W'({$urandom(), $urandom()});
    write_own_mac(mac);
    // responder stays armed after a reply; no idling on either side
    steady_flow <= 1'b1;
    send_frame(build_frame(arpr_pkg::HDR_LEN + 1, arpr_pkg::OP_REQUEST, 8'h00), -1);
    wait_for_drain();
    steady_flow <= 1'b0;
    // wrong EtherType: nothing
    frm = build_frame(arpr_pkg::HDR_LEN, arpr_pkg::OP_REQUEST, -1);
    frm[arpr_pkg::IDX_TYPE_LO] = ETYPE_IPV4_LO;
    send_frame(frm, -1);
    // unknown opcode: nothing
    send_frame(build_frame(arpr_pkg::HDR_LEN, OP_UNKNOWN, -1), -1);
    // ARP reply seen: one notice, responder disarmed
    send_frame(build_frame(arpr_pkg::HDR_LEN, arpr_pkg::OP_REPLY, -1), -1);
    // request while disarmed: nothing
    send_frame(build_frame(arpr_pkg::HDR_LEN, arpr_pkg::OP_REQUEST, -1), -1);

    wait_for_drain();
    repeat (END_CYCLES) @(posedge clk);

    $display("run covered %0d requests, %0d frame ends and %0d own-MAC writes",
             requests_sent, tracker.frames_ended, mac_writes);
    $display("the block owed %0d reply frames and %0d notices; %0d faults",
             tracker.replies_built, tracker.notices_built, tracker.errors);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/arpr_pkg.sv
rtl/arpr_ram.sv
rtl/arpr_rx.sv
rtl/arpr_jobq.sv
rtl/arpr_tx.sv
rtl/arp_request_responder_top.sv
rtl/arpr_chk.sv
bench/testbench.sv
